// ===== src/tbd_pkg.sv =====
// Package for the toroidal blur block: command and state types, register
// indexes, field widths and arithmetic constants. No dependencies.

package tbd_pkg;

	localparam int MAX_WIDTH_LOG2_DEF  = 8;
	localparam int MAX_HEIGHT_LOG2_DEF = 8;

	localparam int CELL_W  = 32;
	localparam int LOG2_W  = 4;
	localparam int DECAY_W = 17;
	localparam int ACC_W   = CELL_W + 4;
	localparam int DIGIT_W = 17;
	localparam int CUR_W   = DIGIT_W + 2;
	localparam int RECIP_W = 20;
	localparam int RECIP_SHIFT = 21;
	localparam int PROD_W  = CELL_W + DECAY_W;

	localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(699051);

	localparam logic [LOG2_W-1:0]  WIDTH_LOG2_RST  = LOG2_W'(8);
	localparam logic [LOG2_W-1:0]  HEIGHT_LOG2_RST = LOG2_W'(8);
	localparam logic [DECAY_W-1:0] DECAY_RST       = DECAY_W'(65536);

	localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
	localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
	localparam logic [1:0] REG_DECAY       = 2'd2;

	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_BLUR   = 1'b1;

	localparam logic [1:0] TAP_LOW  = 2'd0;
	localparam logic [1:0] TAP_MID  = 2'd1;
	localparam logic [1:0] TAP_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_DIV_HI,
		ST_DIV_LO,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mem_write;
		logic       mem_read;
		logic [1:0] row_sel;
		logic [1:0] col_sel;
		logic       div_en;
		logic       div_lo;
		logic       mul_en;
		logic       out_load;
	} dp_cmd_t;

endpackage

// ===== src/toroidal_blur_with_decay.sv =====
// Top level of the toroidal 3x3 weighted blur with decay: configuration
// registers on an APB-style port, controller and datapath.
// Depends on tbd_pkg, tbd_ctrl and tbd_dpath.
//
//   Channel   Handshake                      Payload
//   request   req_valid / req_ready          cmd, x, y, value
//   response  rsp_valid / rsp_ready          kind, blurred
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A write transaction passes through the write and done states before the next one
// is accepted. A compute transaction makes nine reads of the single-port cell
// memory, then a drain step, a two-digit divide, a multiply and the output load.
// The response register lets a new transaction start while a result waits.
// Reset clears the control state and the configuration registers; the cell memory is not cleared.

module toroidal_blur_with_decay #(
	parameter int MAX_WIDTH_LOG2  = tbd_pkg::MAX_WIDTH_LOG2_DEF,
	parameter int MAX_HEIGHT_LOG2 = tbd_pkg::MAX_HEIGHT_LOG2_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       cmd,
	input  logic [7:0]                 x,
	input  logic [7:0]                 y,
	input  logic [tbd_pkg::CELL_W-1:0] value,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic                       kind,
	output logic [tbd_pkg::CELL_W-1:0] blurred,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import tbd_pkg::*;

	logic [LOG2_W-1:0]  width_log2_q;
	logic [LOG2_W-1:0]  height_log2_q;
	logic [DECAY_W-1:0] decay_q;
	logic               cfg_wr;
	dp_cmd_t            dp_cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= WIDTH_LOG2_RST;
			height_log2_q <= HEIGHT_LOG2_RST;
			decay_q       <= DECAY_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH_LOG2:  width_log2_q  <= pwdata[LOG2_W-1:0];
				REG_HEIGHT_LOG2: height_log2_q <= pwdata[LOG2_W-1:0];
				REG_DECAY:       decay_q       <= pwdata[DECAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH_LOG2:  prdata = 32'(width_log2_q);
			REG_HEIGHT_LOG2: prdata = 32'(height_log2_q);
			REG_DECAY:       prdata = 32'(decay_q);
			default:         prdata = '0;
		endcase
	end

	tbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.dp_cmd    (dp_cmd)
	);

	tbd_dpath #(
		.MAX_WIDTH_LOG2  (MAX_WIDTH_LOG2),
		.MAX_HEIGHT_LOG2 (MAX_HEIGHT_LOG2)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.width_log2  (width_log2_q),
		.height_log2 (height_log2_q),
		.decay       (decay_q),
		.req_cmd     (cmd),
		.req_x       (x),
		.req_y       (y),
		.req_value   (value),
		.kind        (kind),
		.blurred     (blurred)
	);

endmodule

// ===== src/tbd_ctrl.sv =====
// Controller state machine of the toroidal blur block.
// Sequences writes, the nine neighborhood reads, divide, scale and output.
// Depends on tbd_pkg.

module tbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              req_cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tbd_pkg::dp_cmd_t  dp_cmd
);
	import tbd_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] row_q, row_d;
	logic [1:0] col_q, col_d;
	logic       rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= TAP_LOW;
			col_q       <= TAP_LOW;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			if (dp_cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		req_ready = 1'b0;
		dp_cmd    = '0;
		dp_cmd.row_sel = row_q;
		dp_cmd.col_sel = col_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					dp_cmd.load = 1'b1;
					row_d = TAP_LOW;
					col_d = TAP_LOW;
					state_d = (req_cmd == CMD_COMPUTE) ? ST_READ : ST_WRITE;
				end
			end
			ST_WRITE: begin
				dp_cmd.mem_write = 1'b1;
				dp_cmd.row_sel   = TAP_MID;
				dp_cmd.col_sel   = TAP_MID;
				state_d = ST_DONE;
			end
			ST_READ: begin
				dp_cmd.mem_read = 1'b1;
				if (col_q == TAP_HIGH) begin
					col_d = TAP_LOW;
					if (row_q == TAP_HIGH) begin
						state_d = ST_DRAIN;
					end else begin
						row_d = row_q + 2'd1;
					end
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DIV_HI;
			end
			ST_DIV_HI: begin
				dp_cmd.div_en = 1'b1;
				state_d = ST_DIV_LO;
			end
			ST_DIV_LO: begin
				dp_cmd.div_en = 1'b1;
				dp_cmd.div_lo = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				dp_cmd.mul_en = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					dp_cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("A waiting result would be overwritten.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("A new transaction was taken while one is in work.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.load, dp_cmd.mem_write, dp_cmd.mem_read, dp_cmd.div_en,
			dp_cmd.mul_en, dp_cmd.out_load}))
		else $error("Conflicting datapath commands.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_HI) |-> ($past(state_q) == ST_DRAIN))
		else $error("Divide started before the last read was summed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |=> rsp_valid)
		else $error("Loaded result is not presented.");

endmodule

// ===== src/tbd_dpath.sv =====
// Datapath of the toroidal blur block: cell memory, wrapped addressing,
// weighted accumulation, divide by twelve and decay scaling.
// Depends on tbd_pkg.

module tbd_dpath #(
	parameter int MAX_WIDTH_LOG2  = tbd_pkg::MAX_WIDTH_LOG2_DEF,
	parameter int MAX_HEIGHT_LOG2 = tbd_pkg::MAX_HEIGHT_LOG2_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbd_pkg::dp_cmd_t              dp_cmd,
	input  logic [tbd_pkg::LOG2_W-1:0]    width_log2,
	input  logic [tbd_pkg::LOG2_W-1:0]    height_log2,
	input  logic [tbd_pkg::DECAY_W-1:0]   decay,
	input  logic                          req_cmd,
	input  logic [7:0]                    req_x,
	input  logic [7:0]                    req_y,
	input  logic [tbd_pkg::CELL_W-1:0]    req_value,
	output logic                          kind,
	output logic [tbd_pkg::CELL_W-1:0]    blurred
);
	import tbd_pkg::*;

	localparam int MW    = MAX_WIDTH_LOG2;
	localparam int MH    = MAX_HEIGHT_LOG2;
	localparam int AW    = MW + MH;
	localparam int DEPTH = 1 << AW;
	localparam int XEW   = (MW > 8) ? MW : 8;
	localparam int YEW   = (MH > 8) ? MH : 8;

	logic [LOG2_W-1:0] wl_eff, hl_eff;
	logic [MW-1:0]     xmask, col_c;
	logic [MH-1:0]     ymask, row_c;
	logic [XEW-1:0]    x_ext;
	logic [YEW-1:0]    y_ext;

	logic [MW-1:0]     cols_q [3];
	logic [MH-1:0]     rows_q [3];
	logic              cmd_q;
	logic [CELL_W-1:0] value_q;

	logic [MW-1:0]     col_sel;
	logic [MH-1:0]     row_sel;
	logic [AW-1:0]     addr;

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;
	logic              rd_valid_s1;
	logic              center_s1;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  addend;

	logic [ACC_W-3:0]           dividend;
	logic [CUR_W-1:0]           cur;
	logic [CUR_W+RECIP_W-1:0]   recip_prod;
	logic [DIGIT_W-1:0]         qdig;
	logic [CUR_W-1:0]           rem_full;
	logic [1:0]                 rem_q;
	logic [CELL_W-DIGIT_W-1:0]  qhi_q;
	logic [CELL_W-1:0]          quot_q;
	logic [PROD_W-1:0]          prod_q;
	logic [PROD_W-17:0]         scaled;
	logic [CELL_W-1:0]          sat;
	logic                       kind_q;
	logic [CELL_W-1:0]          blurred_q;

	assign wl_eff = (width_log2 > LOG2_W'(MW)) ? LOG2_W'(MW) : width_log2;
	assign hl_eff = (height_log2 > LOG2_W'(MH)) ? LOG2_W'(MH) : height_log2;
	assign xmask  = ~({MW{1'b1}} << wl_eff);
	assign ymask  = ~({MH{1'b1}} << hl_eff);
	assign x_ext  = XEW'(req_x);
	assign y_ext  = YEW'(req_y);
	assign col_c  = x_ext[MW-1:0] & xmask;
	assign row_c  = y_ext[MH-1:0] & ymask;

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q     <= req_cmd;
			value_q   <= req_value;
			cols_q[0] <= (col_c - MW'(1)) & xmask;
			cols_q[1] <= col_c;
			cols_q[2] <= (col_c + MW'(1)) & xmask;
			rows_q[0] <= (row_c - MH'(1)) & ymask;
			rows_q[1] <= row_c;
			rows_q[2] <= (row_c + MH'(1)) & ymask;
		end
	end

	always_comb begin
		case (dp_cmd.col_sel)
			TAP_LOW:  col_sel = cols_q[0];
			TAP_HIGH: col_sel = cols_q[2];
			default:  col_sel = cols_q[1];
		endcase
		case (dp_cmd.row_sel)
			TAP_LOW:  row_sel = rows_q[0];
			TAP_HIGH: row_sel = rows_q[2];
			default:  row_sel = rows_q[1];
		endcase
	end

	assign addr = (AW'(row_sel) << wl_eff) | AW'(col_sel);

	always_ff @(posedge clk) begin
		if (dp_cmd.mem_write) begin
			mem[addr] <= value_q;
		end
		if (dp_cmd.mem_read) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			center_s1   <= 1'b0;
		end else begin
			rd_valid_s1 <= dp_cmd.mem_read;
			center_s1   <= (dp_cmd.row_sel == TAP_MID) && (dp_cmd.col_sel == TAP_MID);
		end
	end

	assign addend = center_s1 ? {2'b00, rdata_q, 2'b00} : ACC_W'(rdata_q);

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			acc_q <= '0;
		end else if (rd_valid_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	// Sum / 12 is (sum >> 2) / 3, taken as two digits by a reciprocal multiply.
	assign dividend   = acc_q[ACC_W-1:2];
	assign cur        = dp_cmd.div_lo ? {rem_q, dividend[DIGIT_W-1:0]}
	                                  : {2'b00, dividend[2*DIGIT_W-1:DIGIT_W]};
	assign recip_prod = cur * RECIP_3;
	assign qdig       = recip_prod[RECIP_SHIFT+DIGIT_W-1:RECIP_SHIFT];
	assign rem_full   = cur - ({2'b00, qdig} + {1'b0, qdig, 1'b0});

	always_ff @(posedge clk) begin
		if (dp_cmd.div_en) begin
			rem_q <= rem_full[1:0];
			if (dp_cmd.div_lo) begin
				quot_q <= {qhi_q, qdig};
			end else begin
				qhi_q <= qdig[CELL_W-DIGIT_W-1:0];
			end
		end
		if (dp_cmd.mul_en) begin
			prod_q <= quot_q * decay;
		end
	end

	assign scaled = prod_q[PROD_W-1:16];
	assign sat    = scaled[PROD_W-17] ? {CELL_W{1'b1}} : scaled[CELL_W-1:0];

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			kind_q    <= (cmd_q == CMD_COMPUTE) ? KIND_BLUR : KIND_ACK;
			blurred_q <= (cmd_q == CMD_COMPUTE) ? sat : '0;
		end
	end

	assign kind    = kind_q;
	assign blurred = blurred_q;

endmodule

// ===== verif/toroidal_blur_with_decay_test.sv =====
// Self-checking testbench for toroidal_blur_with_decay: directed and random
// cell writes and blur computes, checked against a grid model kept here.
// Depends on tbd_pkg and the toroidal_blur_with_decay RTL.

module toroidal_blur_with_decay_test;
	import tbd_pkg::*;

	localparam int MAX_W = MAX_WIDTH_LOG2_DEF;
	localparam int MAX_H = MAX_HEIGHT_LOG2_DEF;
	localparam int GRID_CELLS = 1 << (MAX_W + MAX_H);
	localparam int CENTER_WEIGHT = 4;
	localparam int BLUR_DIVISOR = 12;
	localparam int RANDOM_TARGET = 1850;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic              kind;
		logic [CELL_W-1:0] blurred;
	} result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic                cmd = CMD_WRITE;
	logic [7:0]          x = '0;
	logic [7:0]          y = '0;
	logic [CELL_W-1:0]   value = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic                kind;
	logic [CELL_W-1:0]   blurred;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [3:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	logic [CELL_W-1:0]   grid [0:GRID_CELLS-1];
	bit                  written [0:GRID_CELLS-1];
	logic [LOG2_W-1:0]   width_reg = WIDTH_LOG2_RST;
	logic [LOG2_W-1:0]   height_reg = HEIGHT_LOG2_RST;
	logic [DECAY_W-1:0]  decay_reg = DECAY_RST;

	result_t             pending_results [$];
	result_t             oldest;
	bit                  failed = 1'b0;
	bit                  gaps_on = 1'b1;
	int                  hold_len = 0;
	int                  items_sent = 0;
	int                  cycle_count = 0;

	toroidal_blur_with_decay uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.x(x),
		.y(y),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.kind(kind),
		.blurred(blurred),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("toroidal_blur_with_decay regression: fail");
			$finish;
		end
	end

	function automatic int eff_width_log2();
		return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
	endfunction

	function automatic int eff_height_log2();
		return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
	endfunction

	function automatic logic [15:0] cell_index(int row, int col, int wl);
		return 16'((row << wl) | col);
	endfunction

	// Updates the grid for a write, or works out the blurred and decayed cell.
	function automatic result_t blur_or_store(logic c, logic [7:0] xi, logic [7:0] yi,
			logic [CELL_W-1:0] v);
		int wl, hl, xmask, ymask, cx, cy, dx, dy, row, col;
		logic [15:0] a;
		logic [63:0] acc, scaled;
		result_t r;
		wl = eff_width_log2();
		hl = eff_height_log2();
		xmask = (1 << wl) - 1;
		ymask = (1 << hl) - 1;
		cx = int'(xi) & xmask;
		cy = int'(yi) & ymask;
		if (c == CMD_WRITE) begin
			a = cell_index(cy, cx, wl);
			grid[a] = v;
			written[a] = 1'b1;
			r.kind = KIND_ACK;
			r.blurred = '0;
		end else begin
			acc = '0;
			for (dy = -1; dy <= 1; dy++) begin
				for (dx = -1; dx <= 1; dx++) begin
					row = (cy + dy) & ymask;
					col = (cx + dx) & xmask;
					acc += 64'(grid[cell_index(row, col, wl)])
						* 64'((dx == 0 && dy == 0) ? CENTER_WEIGHT : 1);
				end
			end
			scaled = ((acc / 64'(BLUR_DIVISOR)) * 64'(decay_reg)) >> 16;
			if (scaled > 64'hFFFF_FFFF) begin
				scaled = 64'hFFFF_FFFF;
			end
			r.kind = KIND_BLUR;
			r.blurred = scaled[CELL_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] rand_cell();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return CELL_W'($urandom_range(0, 255)) << 16;
			default: return CELL_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic c, input logic [7:0] xi, input logic [7:0] yi,
			input logic [CELL_W-1:0] v);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		x <= xi;
		y <= yi;
		value <= v;
		do @(posedge clk); while (req_ready !== 1'b1);
		pending_results.push_back(blur_or_store(c, xi, yi, v));
		items_sent++;
	endtask

	task automatic write_cell(input logic [7:0] xi, input logic [7:0] yi,
			input logic [CELL_W-1:0] v);
		send_item(CMD_WRITE, xi, yi, v);
	endtask

	// Writes every cell of the neighborhood that has not been written yet,
	// then asks for the blurred cell.
	task automatic blur_at(input logic [7:0] xi, input logic [7:0] yi);
		int wl, hl, xmask, ymask, cx, cy, dx, dy, row, col;
		wl = eff_width_log2();
		hl = eff_height_log2();
		xmask = (1 << wl) - 1;
		ymask = (1 << hl) - 1;
		cx = int'(xi) & xmask;
		cy = int'(yi) & ymask;
		for (dy = -1; dy <= 1; dy++) begin
			for (dx = -1; dx <= 1; dx++) begin
				row = (cy + dy) & ymask;
				col = (cx + dx) & xmask;
				if (!written[cell_index(row, col, wl)]) begin
					write_cell(8'(col | (int'($urandom) & ~xmask)),
						8'(row | (int'($urandom) & ~ymask)), rand_cell());
				end
			end
		end
		send_item(CMD_COMPUTE, xi, yi, CELL_W'($urandom));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic configure(input logic [LOG2_W-1:0] wl, input logic [LOG2_W-1:0] hl,
			input logic [DECAY_W-1:0] dec);
		logic [1:0] idx;
		logic [31:0] data;
		int i;
		wait_idle();
		for (i = 0; i < 3; i++) begin
			case (i)
				0: begin idx = REG_WIDTH_LOG2; data = 32'(wl); end
				1: begin idx = REG_HEIGHT_LOG2; data = 32'(hl); end
				default: begin idx = REG_DECAY; data = 32'(dec); end
			endcase
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx, 2'b00};
			pwdata <= data;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (pready !== 1'b1);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		width_reg = wl;
		height_reg = hl;
		decay_reg = dec;
	endtask

	task automatic test_reset_defaults();
		logic [7:0] coords [3];
		coords = '{8'hFF, 8'h00, 8'h01};
		foreach (coords[i]) begin
			foreach (coords[j]) begin
				write_cell(coords[i], coords[j], '1);
			end
		end
		blur_at(8'h00, 8'h00);
	endtask

	task automatic test_wrap_edges();
		configure(4'd2, 4'd1, 17'd65536);
		blur_at(8'hFF, 8'hFF);
		blur_at(8'h00, 8'h00);
		blur_at(8'h80, 8'h7E);
	endtask

	task automatic test_oversized_log2_and_decay();
		configure(4'd15, 4'd9, 17'h1FFFF);
		blur_at(8'h00, 8'h00);
		configure(4'd15, 4'd15, 17'd0);
		blur_at(8'h00, 8'hFF);
	endtask

	task automatic test_geometry_change();
		configure(4'd0, 4'd0, 17'd65535);
		blur_at(8'hA5, 8'h5A);
		configure(4'd1, 4'd0, 17'd32768);
		blur_at(8'h01, 8'h00);
	endtask

	task automatic test_backpressure();
		int i;
		configure(4'd1, 4'd1, 17'd65536);
		gaps_on = 1'b0;
		hold_len = 300;
		for (i = 0; i < 30; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				write_cell(8'($urandom), 8'($urandom), rand_cell());
			end else begin
				blur_at(8'($urandom), 8'($urandom));
			end
		end
		wait_idle();
		gaps_on = 1'b1;
	endtask

	function automatic logic [LOG2_W-1:0] rand_log2();
		case ($urandom_range(0, 9))
			6, 7: return LOG2_W'($urandom_range(4, 8));
			8: return LOG2_W'(8);
			9: return LOG2_W'($urandom_range(9, 15));
			default: return LOG2_W'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [DECAY_W-1:0] rand_decay();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return DECAY_W'(65536);
			2: return '1;
			3: return DECAY_W'($urandom_range(65537, 131071));
			default: return DECAY_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// Random phases, each under its own geometry and decay. Most coordinates
	// fall into a small window so that large grids still get computes.
	task automatic test_random_mix();
		int n, i;
		logic [7:0] bx, by, xi, yi;
		while (items_sent < RANDOM_TARGET) begin
			configure(rand_log2(), rand_log2(), rand_decay());
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) begin
				hold_len = $urandom_range(50, 200);
			end
			bx = 8'($urandom);
			by = 8'($urandom);
			n = $urandom_range(40, 120);
			for (i = 0; i < n && items_sent < RANDOM_TARGET; i++) begin
				if ($urandom_range(0, 3) != 0) begin
					xi = bx + 8'($urandom_range(0, 7));
					yi = by + 8'($urandom_range(0, 7));
				end else begin
					xi = 8'($urandom);
					yi = 8'($urandom);
				end
				if ($urandom_range(0, 9) < 3) begin
					write_cell(xi, yi, rand_cell());
				end else begin
					blur_at(xi, yi);
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end else begin
				stall = gaps_on ? $urandom_range(0, 12) : 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (rsp_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$error("response transaction with no expectation: kind %b blurred %h",
					kind, blurred);
				failed = 1'b1;
			end else begin
				oldest = pending_results.pop_front();
				if (kind !== oldest.kind) begin
					$error("kind mismatch: expected %b, actual %b", oldest.kind, kind);
					failed = 1'b1;
				end
				if (blurred !== oldest.blurred) begin
					$error("blurred mismatch: expected %h, actual %h",
						oldest.blurred, blurred);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_wrap_edges();
		test_oversized_log2_and_decay();
		test_geometry_change();
		test_backpressure();
		test_random_mix();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && pending_results.size() == 0) begin
			$display("toroidal_blur_with_decay regression: pass");
		end else begin
			$display("toroidal_blur_with_decay regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/tbd_pkg.sv
src/tbd_ctrl.sv
src/tbd_dpath.sv
src/toroidal_blur_with_decay.sv
verif/toroidal_blur_with_decay_test.sv
